>>> rtl/bpq_pkg.sv
`timescale 1ns / 1ps

package bpq_pkg;

	// Fixed widths of the request, result and register fields
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 2;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Operation broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

>>> rtl/bpq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted row. Entries are kept highest priority first,
// older before younger among equal priorities.
module bpq_cell #(
	parameter int VALUE_WIDTH = 16,
	parameter int PRIO_WIDTH  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bpq_pkg::cell_ctrl_t     ctrl,
	input  logic [VALUE_WIDTH-1:0]  new_value,
	input  logic [PRIO_WIDTH-1:0]   new_prio,
	input  logic                    left_valid,
	input  logic [VALUE_WIDTH-1:0]  left_value,
	input  logic [PRIO_WIDTH-1:0]   left_prio,
	input  logic                    left_goes,
	input  logic                    right_valid,
	input  logic [VALUE_WIDTH-1:0]  right_value,
	input  logic [PRIO_WIDTH-1:0]   right_prio,
	output logic                    valid,
	output logic [VALUE_WIDTH-1:0]  value,
	output logic [PRIO_WIDTH-1:0]   prio,
	output logic                    goes
);

	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [PRIO_WIDTH-1:0]  prio_q;

	// Keep this entry ahead of a new one of lower or equal priority
	assign goes = valid_q && (prio_q >= new_prio);

	// Occupancy: shift left on remove, take new or left neighbor on insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.rem) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && !goes) begin
			valid_q <= left_goes ? 1'b1 : left_valid;
		end
	end

	// Entry payload follows the same moves
	always_ff @(posedge clk) begin
		if (ctrl.rem) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end else if (ctrl.ins && !goes) begin
			if (left_goes) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign prio  = prio_q;

endmodule

>>> rtl/bounded_priority_queue.sv
`timescale 1ns / 1ps

// Channel   Valid       Stall       Payload
// request   req_valid   req_stall   req_type, item_value, item_priority
// result    res_valid   res_stall   status, out_value, out_priority, count
// config    cfg_wr_en   -           cfg_wr_data (capacity)
//
// Each transaction first registers the request; then the row of cells inserts
// or shifts in parallel and loads the result register, once that register is free.
// A new request is taken once the held one has moved into the result register.
// Reset empties the row at once and sets capacity to 16.
// A stalled result holds the row; the request register then stalls upstream.
module bounded_priority_queue #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int PRIO_WIDTH  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bpq_pkg::CAP_W-1:0]     cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic [VALUE_WIDTH-1:0]        item_value,
	input  logic [PRIO_WIDTH-1:0]         item_priority,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [bpq_pkg::STATUS_W-1:0]  status,
	output logic [VALUE_WIDTH-1:0]        out_value,
	output logic [PRIO_WIDTH-1:0]         out_priority,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > bpq_pkg::CAP_W) ? CNT_W : bpq_pkg::CAP_W;

	logic [bpq_pkg::CAP_W-1:0] cap_q;
	logic                      busy_q;
	logic                      type_q;
	logic [VALUE_WIDTH-1:0]    value_q;
	logic [PRIO_WIDTH-1:0]     prio_q;
	logic [CNT_W-1:0]          ent_cnt_q;
	logic                      res_valid_q;
	bpq_pkg::status_t          status_q;
	logic [VALUE_WIDTH-1:0]    res_value_q;
	logic [PRIO_WIDTH-1:0]     res_prio_q;
	logic [CNT_W-1:0]          res_cnt_q;

	logic                      fire;
	logic                      full;
	logic                      empty;
	bpq_pkg::cell_ctrl_t       ctrl;

	logic                      c_valid [DEPTH];
	logic [VALUE_WIDTH-1:0]    c_value [DEPTH];
	logic [PRIO_WIDTH-1:0]     c_prio  [DEPTH];
	logic                      c_goes  [DEPTH];

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bpq_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Execute the held request when the result register is free
	assign fire      = busy_q && (!res_valid_q || !res_stall);
	assign req_stall = busy_q;

	assign full  = (CMP_W'(ent_cnt_q) >= CMP_W'(cap_q)) || (ent_cnt_q == CNT_W'(DEPTH));
	assign empty = (ent_cnt_q == '0);

	always_comb begin
		ctrl.ins = fire && (type_q == bpq_pkg::REQ_INSERT) && !full;
		ctrl.rem = fire && (type_q == bpq_pkg::REQ_REMOVE) && !empty;
	end

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_valid && !req_stall) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			type_q  <= req_type;
			value_q <= item_value;
			prio_q  <= item_priority;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_cnt_q <= '0;
		end else if (ctrl.ins) begin
			ent_cnt_q <= CNT_W'(ent_cnt_q + 1'b1);
		end else if (ctrl.rem) begin
			ent_cnt_q <= CNT_W'(ent_cnt_q - 1'b1);
		end
	end

	// Row of cells, head at index zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   l_valid;
		logic [VALUE_WIDTH-1:0] l_value;
		logic [PRIO_WIDTH-1:0]  l_prio;
		logic                   l_goes;
		logic                   r_valid;
		logic [VALUE_WIDTH-1:0] r_value;
		logic [PRIO_WIDTH-1:0]  r_prio;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_value = '0;
			assign l_prio  = '0;
			assign l_goes  = 1'b1;
		end else begin : g_mid
			assign l_valid = c_valid[i-1];
			assign l_value = c_value[i-1];
			assign l_prio  = c_prio[i-1];
			assign l_goes  = c_goes[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_value = '0;
			assign r_prio  = '0;
		end else begin : g_body
			assign r_valid = c_valid[i+1];
			assign r_value = c_value[i+1];
			assign r_prio  = c_prio[i+1];
		end

		bpq_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.PRIO_WIDTH  (PRIO_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (value_q),
			.new_prio    (prio_q),
			.left_valid  (l_valid),
			.left_value  (l_value),
			.left_prio   (l_prio),
			.left_goes   (l_goes),
			.right_valid (r_valid),
			.right_value (r_value),
			.right_prio  (r_prio),
			.valid       (c_valid[i]),
			.value       (c_value[i]),
			.prio        (c_prio[i]),
			.goes        (c_goes[i])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_value_q <= '0;
			res_prio_q  <= '0;
			if (type_q == bpq_pkg::REQ_INSERT) begin
				status_q  <= full ? bpq_pkg::ST_FULL : bpq_pkg::ST_INSERTED;
				res_cnt_q <= full ? ent_cnt_q : CNT_W'(ent_cnt_q + 1'b1);
			end else if (empty) begin
				status_q  <= bpq_pkg::ST_EMPTY;
				res_cnt_q <= ent_cnt_q;
			end else begin
				status_q    <= bpq_pkg::ST_REMOVED;
				res_value_q <= c_value[0];
				res_prio_q  <= c_prio[0];
				res_cnt_q   <= CNT_W'(ent_cnt_q - 1'b1);
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign out_value    = res_value_q;
	assign out_priority = res_prio_q;
	assign count        = res_cnt_q;

endmodule

>>> rtl/bpq_checker.sv
`timescale 1ns / 1ps

module bpq_props #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int PRIO_WIDTH  = 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [bpq_pkg::STATUS_W-1:0]  status,
	input logic [VALUE_WIDTH-1:0]        out_value,
	input logic [PRIO_WIDTH-1:0]         out_priority,
	input logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(count)
			&& $stable(out_value) && $stable(out_priority))
		else $error("stalled result changed");

	// Take one transaction at a time: stall right after an accepted request
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is held");

	// Count never passes the row length
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> count <= CNT_W'(DEPTH))
		else $error("count beyond depth");

	// Insert results carry no entry
	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == bpq_pkg::ST_INSERTED || status == bpq_pkg::ST_FULL)
			|-> out_value == '0 && out_priority == '0)
		else $error("insert result carries an entry");

	// Empty result means nothing is held
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == bpq_pkg::ST_EMPTY |-> count == '0
			&& out_value == '0 && out_priority == '0)
		else $error("empty result with entries held");

endmodule

bind bounded_priority_queue bpq_props #(
	.DEPTH       (DEPTH),
	.VALUE_WIDTH (VALUE_WIDTH),
	.PRIO_WIDTH  (PRIO_WIDTH)
) u_bpq_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.status       (status),
	.out_value    (out_value),
	.out_priority (out_priority),
	.count        (count)
);
